// ===== rtl/core/adc_dds_phase_alignment_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef ADC_DDS_PHASE_ALIGNMENT_CORE_ASSERT_SVH
`define ADC_DDS_PHASE_ALIGNMENT_CORE_ASSERT_SVH
// Implication checked only while the block is out of reset.
`define APA_ASSERT_RUN(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked at every clock edge.
`define APA_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/apa_pkg.sv =====
package apa_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int FREQ_FRAC_BITS = 8;
  localparam int WORD_W         = 32;
  localparam int ELAPSED_W      = 31;
  localparam int PROD_W         = WORD_W + ELAPSED_W;
  localparam int DEN_W          = WORD_W + FREQ_FRAC_BITS;
  localparam int NUM_W          = PROD_W + PHASE_BITS;
  localparam int DIV_STEPS      = NUM_W;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    CFG_SAMPLE_RATE = 8'd0,
    CFG_CORE_CLOCK  = 8'd1,
    CFG_CAL_PHASE   = 8'd2,
    CFG_MAX_UNC     = 8'd3
  } cfg_reg_t;

  // One restoring divider lane: remainder, numerator bits still to shift in,
  // divisor and the low quotient bits.
  typedef struct packed {
    logic [DEN_W-1:0]      rem;
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;
    logic [PHASE_BITS-1:0] q;
  } lane_t;

  // Word carried along the divider chain.
  typedef struct packed {
    logic                  chk;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [PHASE_BITS-1:0] goertzel;
    logic [PHASE_BITS-1:0] dds;
    lane_t                 l1;
    lane_t                 l2;
  } tok_t;

  // One quotient bit of restoring division.
  function automatic lane_t div_step(lane_t l);
    logic [DEN_W:0] t;
    lane_t          r;
    r     = l;
    t     = {l.rem, l.num[NUM_W-1]};
    r.num = {l.num[NUM_W-2:0], 1'b0};
    if (t >= {1'b0, l.den}) begin
      r.rem = DEN_W'(t - {1'b0, l.den});
      r.q   = {l.q[PHASE_BITS-2:0], 1'b1};
    end else begin
      r.rem = t[DEN_W-1:0];
      r.q   = {l.q[PHASE_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/adc_dds_if.sv =====
// Measurement channel.
interface adc_dds_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] goertzel_phase;
  logic [31:0] signal_frequency;
  logic [31:0] adc_start_cycle;
  logic [31:0] anchor_cycle;
  logic [31:0] anchor_uncertainty;
  logic [31:0] dds_phase;
  modport source (output valid, goertzel_phase, signal_frequency, adc_start_cycle,
                  anchor_cycle, anchor_uncertainty, dds_phase, input ready);
  modport sink (input valid, goertzel_phase, signal_frequency, adc_start_cycle,
                anchor_cycle, anchor_uncertainty, dds_phase, output ready);
endinterface

// Result channel.
interface adc_dds_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [30:0]        elapsed_count;
  logic signed [31:0] adc_phase_at_anchor;
  logic [31:0]        dds_phase_at_anchor;
  logic signed [31:0] phase_error;
  modport source (output valid, valid_res, elapsed_count, adc_phase_at_anchor,
                  dds_phase_at_anchor, phase_error, input ready);
  modport sink (input valid, valid_res, elapsed_count, adc_phase_at_anchor,
                dds_phase_at_anchor, phase_error, output ready);
endinterface

// ===== rtl/core/apa_cell.sv =====
// One divider cell: takes one quotient bit in both lanes and passes the word on.
module apa_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  apa_pkg::tok_t up_tok,
  output logic          up_ready,
  output logic          dn_valid,
  output apa_pkg::tok_t dn_tok,
  input  logic          dn_ready
);

  logic          valid_r;
  apa_pkg::tok_t tok_r;
  apa_pkg::tok_t tok_nxt;

  // The cell moves when empty or when its neighbor takes its word.
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    tok_nxt    = up_tok;
    tok_nxt.l1 = apa_pkg::div_step(up_tok.l1);
    tok_nxt.l2 = apa_pkg::div_step(up_tok.l2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

endmodule

// ===== rtl/core/adc_dds_phase_alignment_core.sv =====
// An accepted word passes the check stage, the multiply stage, 95 divider cells and the
// output register in order; a word waits in its stage while the result side stalls.
// One word per cycle without stalls; every stage moves on its own, so bubbles close up.
// The two fractional divisions share the cell chain, one quotient bit per cell.
// Reset (rst_n, synchronous, active low) empties the pipeline and clears all
// configuration registers to zero.
module adc_dds_phase_alignment_core (
  input  logic                clk,
  input  logic                rst_n,
  adc_dds_in_if.sink          in_ch,
  adc_dds_out_if.source       out_ch,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int PB = apa_pkg::PHASE_BITS;
  localparam int EW = apa_pkg::ELAPSED_W;
  localparam int WW = apa_pkg::WORD_W;
  localparam int NS = apa_pkg::DIV_STEPS;

  logic [WW-1:0] sample_rate_r;
  logic [WW-1:0] core_clock_r;
  logic [WW-1:0] cal_phase_r;
  logic [WW-1:0] max_unc_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= '0;
      core_clock_r  <= '0;
      cal_phase_r   <= '0;
      max_unc_r     <= '0;
    end else if (cfg_we) begin
      unique case (apa_pkg::cfg_reg_t'(cfg_index))
        apa_pkg::CFG_SAMPLE_RATE: sample_rate_r <= cfg_wdata;
        apa_pkg::CFG_CORE_CLOCK:  core_clock_r  <= cfg_wdata;
        apa_pkg::CFG_CAL_PHASE:   cal_phase_r   <= cfg_wdata;
        apa_pkg::CFG_MAX_UNC:     max_unc_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Check stage: elapsed count and validity of the measurement.
  logic          s0_v_r;
  logic          s0_chk_r;
  logic [EW-1:0] s0_elapsed_r;
  logic [WW-1:0] s0_goertzel_r;
  logic [WW-1:0] s0_freq_r;
  logic [WW-1:0] s0_dds_r;
  logic          s0_ready;
  logic [WW-1:0] elapsed_full;
  logic          chk_nxt;
  logic          s1_ready;

  assign elapsed_full = in_ch.anchor_cycle - in_ch.adc_start_cycle;
  assign chk_nxt = (in_ch.signal_frequency != '0) && (sample_rate_r != '0) &&
                   (core_clock_r != '0) && (in_ch.anchor_uncertainty <= max_unc_r) &&
                   !elapsed_full[WW-1];
  assign s0_ready    = !s0_v_r || s1_ready;
  assign in_ch.ready = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_ready) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_ch.valid) begin
      s0_chk_r      <= chk_nxt;
      s0_elapsed_r  <= elapsed_full[EW-1:0];
      s0_goertzel_r <= in_ch.goertzel_phase;
      s0_freq_r     <= in_ch.signal_frequency;
      s0_dds_r      <= in_ch.dds_phase;
    end
  end

  // Multiply stage: frequency times elapsed cycles.
  logic                       s1_v_r;
  logic                       s1_chk_r;
  logic [EW-1:0]              s1_elapsed_r;
  logic [WW-1:0]              s1_goertzel_r;
  logic [WW-1:0]              s1_freq_r;
  logic [WW-1:0]              s1_dds_r;
  logic [apa_pkg::PROD_W-1:0] s1_prod_r;
  logic                       cell_ready [0:NS];
  logic                       cell_v     [0:NS];
  apa_pkg::tok_t              cell_tok   [0:NS];

  function automatic logic [apa_pkg::PROD_W-1:0] s1_mul(logic [WW-1:0] a,
                                                         logic [EW-1:0] b);
    return apa_pkg::PROD_W'(a) * apa_pkg::PROD_W'(b);
  endfunction

  assign s1_ready = !s1_v_r || cell_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s0_v_r) begin
      s1_chk_r      <= s0_chk_r;
      s1_elapsed_r  <= s0_elapsed_r;
      s1_goertzel_r <= s0_goertzel_r;
      s1_freq_r     <= s0_freq_r;
      s1_dds_r      <= s0_dds_r;
      s1_prod_r     <= s1_mul(s0_freq_r, s0_elapsed_r);
    end
  end

  // Starting word of the divider chain.
  always_comb begin
    cell_tok[0]          = '0;
    cell_tok[0].chk      = s1_chk_r;
    cell_tok[0].elapsed  = s1_elapsed_r;
    cell_tok[0].goertzel = s1_goertzel_r;
    cell_tok[0].dds      = s1_dds_r;
    cell_tok[0].l1.num   = apa_pkg::NUM_W'({s1_freq_r, PB'(0)});
    cell_tok[0].l1.den   = apa_pkg::DEN_W'(sample_rate_r);
    cell_tok[0].l2.num   = {s1_prod_r, PB'(0)};
    cell_tok[0].l2.den   = {core_clock_r, apa_pkg::FREQ_FRAC_BITS'(0)};
  end
  assign cell_v[0] = s1_v_r;

  // Divider chain.
  for (genvar i = 0; i < NS; i++) begin : g_cell
    apa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cell_v[i]),
      .up_tok   (cell_tok[i]),
      .up_ready (cell_ready[i]),
      .dn_valid (cell_v[i+1]),
      .dn_tok   (cell_tok[i+1]),
      .dn_ready (cell_ready[i+1])
    );
  end

  // Output register: phase sums and wrapped difference.
  logic          out_v_r;
  logic          res_r;
  logic [EW-1:0] elapsed_r;
  logic [PB-1:0] adc_r;
  logic [PB-1:0] dds_r;
  logic [PB-1:0] err_r;
  logic [PB-1:0] adc_nxt;
  apa_pkg::tok_t last;

  assign last          = cell_tok[NS];
  assign cell_ready[NS] = !out_v_r || out_ch.ready;
  assign adc_nxt = last.goertzel + last.l1.q + last.l2.q + cal_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cell_ready[NS]) begin
      out_v_r <= cell_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ready[NS] && cell_v[NS]) begin
      res_r <= last.chk;
      if (last.chk) begin
        elapsed_r <= last.elapsed;
        adc_r     <= adc_nxt;
        dds_r     <= last.dds;
        err_r     <= adc_nxt - last.dds;
      end else begin
        elapsed_r <= '0;
        adc_r     <= '0;
        dds_r     <= '0;
        err_r     <= '0;
      end
    end
  end

  assign out_ch.valid               = out_v_r;
  assign out_ch.valid_res           = res_r;
  assign out_ch.elapsed_count       = elapsed_r;
  assign out_ch.adc_phase_at_anchor = adc_r;
  assign out_ch.dds_phase_at_anchor = dds_r;
  assign out_ch.phase_error         = err_r;

endmodule

// ===== rtl/core/apa_checker.sv =====
`include "adc_dds_phase_alignment_core_assert.svh"

// Port-level checks on the result channel.
module apa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               valid_res,
  input logic [30:0]        elapsed_count,
  input logic signed [31:0] adc_phase,
  input logic [31:0]        dds_phase,
  input logic signed [31:0] phase_error
);

  // A rejected measurement carries only zeros.
  `APA_ASSERT_RUN(a_reject_zero, clk, rst_n, out_valid && !valid_res, (elapsed_count == '0) && (adc_phase == '0) && (dds_phase == '0) && (phase_error == '0), "rejected word has nonzero fields")
  // The error is the wrapped difference of the two phases.
  `APA_ASSERT_RUN(a_err_diff, clk, rst_n, out_valid && valid_res, phase_error == 32'(adc_phase - dds_phase), "phase error mismatch")
  // A stalled word stays offered.
  `APA_ASSERT_RUN(a_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid, "result dropped while stalled")
  // Reset empties the result register.
  `APA_ASSERT_NEXT(a_reset, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind adc_dds_phase_alignment_core apa_checker u_apa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .valid_res      (out_ch.valid_res),
  .elapsed_count  (out_ch.elapsed_count),
  .adc_phase      (out_ch.adc_phase_at_anchor),
  .dds_phase      (out_ch.dds_phase_at_anchor),
  .phase_error    (out_ch.phase_error)
);

// ===== sim/adc_dds_phase_alignment_core_tb.sv =====
module adc_dds_phase_alignment_core_tb;

  // One measurement word as the driver sends it.
  typedef struct {
    logic [31:0] goertzel;
    logic [31:0] freq;
    logic [31:0] start_cyc;
    logic [31:0] anchor_cyc;
    logic [31:0] unc;
    logic [31:0] dds;
  } meas_t;

  // One alignment result word.
  typedef struct {
    logic        vld;
    logic [30:0] elapsed;
    logic [31:0] adc_ph;
    logic [31:0] dds_ph;
    logic [31:0] err;
  } align_t;

  localparam int LATENCY   = 98;
  localparam int STALL_MAX = 40;
  localparam int WDOG_MAX  = 4 * (LATENCY + 2 * STALL_MAX) + 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  adc_dds_in_if  in_ch();
  adc_dds_out_if out_ch();

  adc_dds_phase_alignment_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [31:0] sh_rate, sh_clock, sh_cal, sh_unc_max;

  meas_t  pending_meas[$];
  align_t expected_align[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     valid_seen = 0;
  int     words_sent = 0;
  int     idle_cycles = 0;
  bit     timed_out = 1'b0;
  bit     in_taken = 1'b0;

  // Fractional turns of num/den, truncated, scaled by 2^32.
  function automatic logic [31:0] frac_turns32(logic [127:0] num, logic [127:0] den);
    logic [127:0] r;
    r = ((num % den) << 32) / den;
    return r[31:0];
  endfunction

  // Expected alignment result for one measurement under the current shadow config.
  function automatic align_t align_predict(meas_t m);
    align_t      a;
    logic [31:0] el;
    logic [31:0] adc;
    el = m.anchor_cyc - m.start_cyc;
    a = '{1'b0, '0, '0, '0, '0};
    if (m.freq == 0 || sh_rate == 0 || sh_clock == 0 || m.unc > sh_unc_max ||
        el > 32'h7FFF_FFFF)
      return a;
    adc = m.goertzel + frac_turns32(128'(m.freq), 128'(sh_rate)) +
          frac_turns32(128'(m.freq) * 128'(el),
                       128'(sh_clock) << apa_pkg::FREQ_FRAC_BITS) + sh_cal;
    a.vld = 1'b1;
    a.elapsed = el[30:0];
    a.adc_ph = adc;
    a.dds_ph = m.dds;
    a.err = adc - m.dds;
    return a;
  endfunction

  // Mostly short gaps, now and then a long one, sometimes stretches of none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, STALL_MAX);
  endfunction

  // Acceptance at the rising edge: predict the word and note it for the driver.
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      expected_align.push_back(align_predict(pending_meas.pop_front()));
      words_sent++;
    end
  end

  // Driver: feeds pending words, holding each one until it is taken.
  int drv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the word until it is taken.
    end else if (drv_gap > 0) begin
      drv_gap <= drv_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_meas.size() > 0) begin
      meas_t m;
      m = pending_meas[0];
      in_ch.valid <= 1'b1;
      in_ch.goertzel_phase <= m.goertzel;
      in_ch.signal_frequency <= m.freq;
      in_ch.adc_start_cycle <= m.start_cyc;
      in_ch.anchor_cycle <= m.anchor_cyc;
      in_ch.anchor_uncertainty <= m.unc;
      in_ch.dds_phase <= m.dds;
      drv_gap <= gap_len();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver stalls.
  int rcv_gap = 0;
  always @(negedge clk) begin
    if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      rcv_gap <= gap_len();
    end
  end

  // Monitor: compares each result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      align_t e;
      results_seen++;
      if (expected_align.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result word with nothing expected");
      end else begin
        e = expected_align.pop_front();
        if (e.vld) valid_seen++;
        if (out_ch.valid_res !== e.vld || out_ch.elapsed_count !== e.elapsed ||
            out_ch.adc_phase_at_anchor !== e.adc_ph ||
            out_ch.dds_phase_at_anchor !== e.dds_ph || out_ch.phase_error !== e.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: exp v=%0b el=%h adc=%h dds=%h err=%h, ",
                      "got v=%0b el=%h adc=%h dds=%h err=%h"},
              e.vld, e.elapsed, e.adc_ph, e.dds_ph, e.err, out_ch.valid_res,
              out_ch.elapsed_count, out_ch.adc_phase_at_anchor,
              out_ch.dds_phase_at_anchor, out_ch.phase_error);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired with %0d results outstanding", expected_align.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(apa_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      apa_pkg::CFG_SAMPLE_RATE: sh_rate = val;
      apa_pkg::CFG_CORE_CLOCK:  sh_clock = val;
      apa_pkg::CFG_CAL_PHASE:   sh_cal = val;
      apa_pkg::CFG_MAX_UNC:     sh_unc_max = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] rate, logic [31:0] cclk, logic [31:0] cal,
                           logic [31:0] umax);
    cfg_write(apa_pkg::CFG_SAMPLE_RATE, rate);
    cfg_write(apa_pkg::CFG_CORE_CLOCK, cclk);
    cfg_write(apa_pkg::CFG_CAL_PHASE, cal);
    cfg_write(apa_pkg::CFG_MAX_UNC, umax);
  endtask

  // Waits until every queued word is sent and every result has come back.
  task automatic drain();
    wait (pending_meas.size() == 0 && !in_ch.valid && expected_align.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic meas_t rand_meas(logic [31:0] umax);
    meas_t m;
    int    r;
    m.goertzel = $urandom();
    m.dds = $urandom();
    r = $urandom_range(0, 9);
    m.freq = (r == 0) ? 32'($urandom_range(0, 3)) : (r < 3 ? $urandom() :
             32'($urandom_range(1, 32'h00FF_FFFF)));
    m.start_cyc = $urandom();
    r = $urandom_range(0, 9);
    m.anchor_cyc = m.start_cyc + ((r == 0) ? $urandom() :
                   (r < 3 ? 32'($urandom_range(0, 1000)) : ($urandom() >> 1)));
    r = $urandom_range(0, 9);
    m.unc = (r == 0) ? $urandom() : ((umax == 0) ? 32'd0 : $urandom_range(0, umax));
    return m;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.goertzel_phase = '0;
    in_ch.signal_frequency = '0;
    in_ch.adc_start_cycle = '0;
    in_ch.anchor_cycle = '0;
    in_ch.anchor_uncertainty = '0;
    in_ch.dds_phase = '0;
    out_ch.ready = 1'b0;
    sh_rate = '0; sh_clock = '0; sh_cal = '0; sh_unc_max = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Registers at reset: everything invalid.
    pending_meas.push_back('{32'h1234, 32'h100, 0, 5, 0, 32'h55});
    drain();

    // Directed words at a typical setting.
    configure(32'd1000 << 8, 32'd100_000_000, 32'h0000_1000, 32'd50);
    pending_meas.push_back('{0, 32'd50 << 8, 0, 0, 0, 0});
    pending_meas.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFE,
                             32'd50, 32'hFFFF_FFFF});
    pending_meas.push_back('{5, 32'd50 << 8, 10, 32'h8000_0009, 0, 0});
    pending_meas.push_back('{5, 32'd50 << 8, 10, 32'h8000_000A, 0, 0});
    pending_meas.push_back('{5, 32'd50 << 8, 10, 32'h8000_0000, 0, 0});
    pending_meas.push_back('{5, 0, 0, 100, 0, 7});
    pending_meas.push_back('{5, 32'd7 << 8, 0, 100, 32'd51, 7});
    pending_meas.push_back('{5, 32'd7 << 8, 0, 100, 32'hFFFF_FFFF, 7});
    pending_meas.push_back('{32'h8000_0000 - 32'h0000_1000 - 32'h8000, 32'd500 << 8,
                             0, 0, 0, 0});
    pending_meas.push_back('{32'h8000_0000, 32'd1000 << 8, 0, 0, 0, 32'h0000_1000});
    drain();

    // Extremes: full-scale rates with negative calibration, unit rates with positive calibration.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    pending_meas.push_back('{32'hAAAA_AAAA, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF,
                             32'hFFFF_FFFF, 32'h5555_5555});
    pending_meas.push_back('{32'h5555_5555, 1, 3, 2, 0, 32'hAAAA_AAAA});
    drain();
    configure(1, 1, 32'h7FFF_FFFF, 0);
    pending_meas.push_back('{1, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0, 2});
    pending_meas.push_back('{1, 3, 0, 1, 1, 2});
    drain();

    // Random phases, several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      logic [31:0] umax;
      umax = (ph == 5) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 1000));
      configure((ph == 4) ? 32'($urandom_range(1, 255)) : 32'($urandom_range(1, 32'hFFFF_FFFF)),
                (ph == 3) ? 32'($urandom_range(0, 1)) : $urandom(),
                $urandom(), umax);
      for (int k = 0; k < 100; k++) pending_meas.push_back(rand_meas(umax));
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    $display("Sent %0d measurement words, checked %0d results (%0d valid).",
             words_sent, results_seen, valid_seen);
    if (mismatches == 0 && expected_align.size() == 0 && !timed_out) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/apa_pkg.sv
rtl/core/adc_dds_if.sv
rtl/core/apa_cell.sv
rtl/core/adc_dds_phase_alignment_core.sv
rtl/core/apa_checker.sv
sim/adc_dds_phase_alignment_core_tb.sv
